// ===== rtl/wats_pkg.sv =====
// ============================================================================
// wats_pkg
// Shared types and constants for the Wilder average-true-range smoother.
// ============================================================================
package wats_pkg;

    // Fixed field widths of the interface.
    localparam int SEQ_W   = 32;
    localparam int FIELD_W = 32;
    localparam int PER_W   = 16;
    localparam int LB_W    = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // The recurrence intermediate is saturated to 64 bits, the width of the dividend.
    localparam int DIV_W   = 64;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_PERIOD    = 2'd0;
    localparam logic [IDX_W-1:0] REG_UNTRUSTED = 2'd1;
    localparam logic [IDX_W-1:0] REG_LOOKBACK  = 2'd2;

    // Request type codes.
    localparam logic REQ_CALC = 1'b0;
    localparam logic REQ_PICK = 1'b1;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

    // Status from the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/wats_div.sv =====
// ============================================================================
// wats_div
// Radix-4 restoring divider: a 64-bit dividend by a 16-bit divisor, two
// quotient bits per cycle shifted into the dividend register.
// ============================================================================
module wats_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wats_pkg::DIV_W-1:0]     i_dividend,
    input  logic [wats_pkg::PER_W-1:0]     i_divisor,
    output wats_pkg::t_div_stat            o_stat,
    output logic [wats_pkg::DIV_W-1:0]     o_quotient
);

    localparam int STEPS = wats_pkg::DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int PW    = wats_pkg::PER_W;
    localparam int DW    = wats_pkg::DIV_W;

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [PW-1:0]    r_rem;
    logic [PW-1:0]    r_den;
    logic [DW-1:0]    r_dq;

    logic [PW:0]      w_t1;
    logic [PW:0]      w_t2;
    logic [PW:0]      w_d;
    logic             w_ge1;
    logic             w_ge2;
    logic [PW-1:0]    w_r1;
    logic [PW-1:0]    w_r2;

    // Two compare-and-subtract steps on the partial remainder.
    always_comb begin
        w_d   = {1'b0, r_den};
        w_t1  = {r_rem, r_dq[DW-1]};
        w_ge1 = (w_t1 >= w_d);
        w_r1  = w_ge1 ? PW'(w_t1 - w_d) : w_t1[PW-1:0];
        w_t2  = {w_r1, r_dq[DW-2]};
        w_ge2 = (w_t2 >= w_d);
        w_r2  = w_ge2 ? PW'(w_t2 - w_d) : w_t2[PW-1:0];
    end

    // Control: busy until the last step, done pulses after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top, quotient bits in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DW-3:0], w_ge1, w_ge2};
            r_rem <= w_r2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dq;

endmodule

// ===== rtl/wilder_atr_smoother_top.sv =====
// ============================================================================
// wilder_atr_smoother_top
// Wilder smoothing of a sequence-numbered true-range stream (average true
// range) with a bit-serial multiplier and a radix-4 serial divider.
// ============================================================================
// Usage:
// A sample transaction on the input channel (i_in_valid / o_in_stall) carries
// a request type, a sequence number and a Q16.16 true-range sample. Each one
// produces exactly one result transaction on the output channel
// (o_out_valid / i_out_stall) with the smoothed value and its valid flag; an
// invalid result always carries a zero value. The block works on one sample
// at a time and raises o_in_stall while busy. Work per sample:
//   - ignored or pure warm-up samples: decode only, no multiply or divide,
//   - the seed (sequence number equal to the period): the divider alone,
//   - recurrence samples and previews past the period: the shift-add
//     multiplier, then the 2-bit-per-cycle divider; other previews use the divider alone.
// A finished result sits in the output register; the next sample is taken
// while it waits, and its own result waits in the sequencer until the output
// register is free. Configuration is written on i_cfg_we at any idle time.
// Synchronous reset loads the default registers (period 14, no warm-up,
// lookback 1), clears the running value and empties the output register.
// ============================================================================
module wilder_atr_smoother_top #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [wats_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [wats_pkg::CFG_W-1:0]        i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [wats_pkg::SEQ_W-1:0]        i_seq_num,
    input  logic [wats_pkg::FIELD_W-1:0]      i_true_range,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wats_pkg::FIELD_W-1:0]      o_atr_value,
    output logic                              o_atr_valid
);

    localparam int PW    = wats_pkg::PER_W;
    localparam int DW    = wats_pkg::DIV_W;
    localparam int FW    = wats_pkg::FIELD_W;
    localparam int SW    = wats_pkg::SEQ_W;
    localparam int EXT_W = (ACC_WIDTH + PW > DW + 1) ? ACC_WIDTH + PW : DW + 1;
    localparam int MC_W  = $clog2(PW);
    localparam logic [DW-1:0] SMP_MASK = DW'((65'd1 << SAMPLE_WIDTH) - 65'd1);

    // Configuration registers.
    logic [PW-1:0]              r_period;
    logic [PW-1:0]              r_untrusted;
    logic [wats_pkg::LB_W-1:0]  r_lookback;

    // Sequencer and captured sample.
    wats_pkg::t_state           r_state;
    wats_pkg::t_state           n_state;
    logic                       r_req;
    logic [SW-1:0]              r_seq;
    logic [FW-1:0]              r_smp;

    // Running value and the operation in flight.
    logic [ACC_WIDTH-1:0]       r_rv;
    logic                       r_recur;
    logic                       r_commit;
    logic                       r_ok;
    logic [DW-1:0]              r_res;

    // Shift-add multiplier.
    logic [EXT_W-1:0]           r_mcand;
    logic [EXT_W-1:0]           r_prod;
    logic [PW-1:0]              r_mplier;
    logic [MC_W-1:0]            r_mcnt;

    // Output register.
    logic                       r_out_valid;
    logic [FW-1:0]              r_out_value;
    logic                       r_out_ok;

    // Decode and datapath signals.
    logic [PW-1:0]              w_per;
    logic [PW:0]                w_trust;
    logic                       w_gt_p;
    logic                       w_eq_p;
    logic                       w_lt_trust;
    logic                       w_eq_trust;
    logic                       w_lt_lb;
    logic [DW:0]                w_sum64;
    logic [DW-1:0]              w_sat64;
    logic [ACC_WIDTH:0]         w_suma;
    logic [ACC_WIDTH-1:0]       w_sata;
    logic [DW-1:0]              w_prod64;
    logic [DW:0]                w_num;
    logic [DW-1:0]              w_num_sat;
    logic [DW-1:0]              w_q;
    logic [DW-1:0]              w_qval;
    logic                       w_load;
    logic                       w_div_start;
    logic [DW-1:0]              w_dividend;
    wats_pkg::t_div_stat        w_div_stat;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PW'(14);
            r_untrusted <= '0;
            r_lookback  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wats_pkg::REG_PERIOD:    r_period    <= i_cfg_data;
                wats_pkg::REG_UNTRUSTED: r_untrusted <= i_cfg_data;
                wats_pkg::REG_LOOKBACK:  r_lookback  <= i_cfg_data[wats_pkg::LB_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample classification against period, trust point and lookback.
    always_comb begin
        w_per      = (r_period == '0) ? PW'(1) : r_period;
        w_trust    = {1'b0, w_per} + {1'b0, r_untrusted};
        w_gt_p     = r_seq > SW'(w_per);
        w_eq_p     = r_seq == SW'(w_per);
        w_lt_trust = r_seq < SW'(w_trust);
        w_eq_trust = r_seq == SW'(w_trust);
        w_lt_lb    = r_seq < SW'(r_lookback);
    end

    // Saturating sums of the running value and the sample.
    always_comb begin
        w_sum64 = (DW + 1)'(r_rv) + (DW + 1)'(r_smp);
        w_sat64 = w_sum64[DW] ? {DW{1'b1}} : w_sum64[DW-1:0];
        w_suma  = (ACC_WIDTH + 1)'(r_rv) + (ACC_WIDTH + 1)'(r_smp);
        w_sata  = w_suma[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : w_suma[ACC_WIDTH-1:0];
    end

    // Recurrence numerator: saturated product plus the sample, saturated.
    always_comb begin
        w_prod64  = (|r_prod[EXT_W-1:DW]) ? {DW{1'b1}} : r_prod[DW-1:0];
        w_num     = {1'b0, w_prod64} + (DW + 1)'(r_smp);
        w_num_sat = w_num[DW] ? {DW{1'b1}} : w_num[DW-1:0];
    end

    // Quotient, masked to the accumulator width for the recurrence.
    always_comb begin
        w_qval = r_recur ? DW'(w_q[ACC_WIDTH-1:0]) : w_q;
    end

    assign w_load = (r_state == wats_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // Next state and divider start.
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_dividend  = w_num_sat;
        case (r_state)
            wats_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = wats_pkg::S_DECODE;
                end
            end
            wats_pkg::S_DECODE: begin
                if (r_req == wats_pkg::REQ_PICK) begin
                    if (w_lt_trust) begin
                        n_state = wats_pkg::S_DONE;
                    end else if (w_gt_p) begin
                        n_state = wats_pkg::S_MUL;
                    end else begin
                        w_div_start = 1'b1;
                        w_dividend  = w_sat64;
                        n_state     = wats_pkg::S_DIV;
                    end
                end else if (w_lt_lb) begin
                    n_state = wats_pkg::S_DONE;
                end else if (w_gt_p) begin
                    n_state = wats_pkg::S_MUL;
                end else if (w_eq_p) begin
                    w_div_start = 1'b1;
                    w_dividend  = DW'(w_sata);
                    n_state     = wats_pkg::S_DIV;
                end else begin
                    n_state = wats_pkg::S_DONE;
                end
            end
            wats_pkg::S_MUL: begin
                if (r_mcnt == MC_W'(PW - 1)) begin
                    n_state = wats_pkg::S_SUM;
                end
            end
            wats_pkg::S_SUM: begin
                w_div_start = 1'b1;
                n_state     = wats_pkg::S_DIV;
            end
            wats_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = wats_pkg::S_DONE;
                end
            end
            wats_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = wats_pkg::S_IDLE;
                end
            end
            default: n_state = wats_pkg::S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wats_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Running value; cleared by reset as part of the smoother state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (r_state == wats_pkg::S_DECODE && r_req == wats_pkg::REQ_CALC
                     && !w_lt_lb && !w_gt_p && !w_eq_p) begin
            r_rv <= w_sata;
        end else if (r_state == wats_pkg::S_DIV && w_div_stat.done && r_commit) begin
            r_rv <= w_qval[ACC_WIDTH-1:0];
        end
    end

    // Sample capture, operation flags and the serial multiplier.
    always_ff @(posedge i_clk) begin
        case (r_state)
            wats_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_req <= i_req_type;
                    r_seq <= i_seq_num;
                    r_smp <= i_true_range & SMP_MASK[FW-1:0];
                end
            end
            wats_pkg::S_DECODE: begin
                r_mcand  <= EXT_W'(r_rv);
                r_prod   <= '0;
                r_mplier <= w_per - PW'(1);
                r_mcnt   <= '0;
                r_recur  <= w_gt_p;
                r_commit <= (r_req == wats_pkg::REQ_CALC);
                if (r_req == wats_pkg::REQ_PICK) begin
                    r_ok <= !w_lt_trust;
                end else if (w_gt_p && !w_lt_lb) begin
                    r_ok <= !w_lt_trust;
                end else begin
                    r_ok <= !w_lt_lb && w_eq_p && w_eq_trust;
                end
            end
            wats_pkg::S_MUL: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[EXT_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[PW-1:1]};
                r_mcnt   <= r_mcnt + 1'b1;
            end
            wats_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    r_res <= w_qval;
                end
            end
            default: ;
        endcase
    end

    // Output register: clamp to the sample range, zero when not trusted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ok <= r_ok;
            if (!r_ok) begin
                r_out_value <= '0;
            end else if (r_res > SMP_MASK) begin
                r_out_value <= SMP_MASK[FW-1:0];
            end else begin
                r_out_value <= r_res[FW-1:0];
            end
        end
    end

    wats_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_per),
        .o_stat     (w_div_stat),
        .o_quotient (w_q)
    );

    assign o_in_stall  = (r_state != wats_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_atr_value = r_out_value;
    assign o_atr_valid = r_out_ok;

    // An untrusted result always carries a zero value.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_atr_valid |-> o_atr_value == '0)
        else $error("untrusted result with nonzero value");

    // A reported value never exceeds the sample range.
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> DW'(o_atr_value) <= SMP_MASK)
        else $error("result above sample range");

    // A transaction taken in raises the input stall.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second sample accepted while busy");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    // Waiting in the divide state means the divider is working.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wats_pkg::S_DIV && $past(r_state) == wats_pkg::S_DIV
        && !w_div_stat.done |-> w_div_stat.busy)
        else $error("sequencer waits on an idle divider");

endmodule
